/* src/raid0_stripe_request_splitter_assert.svh */
// Assertion shorthands used by the splitter back module, raid0s_back.
// The module that uses them must have clk and rst_n in scope.
`ifndef RAID0_STRIPE_REQUEST_SPLITTER_ASSERT_SVH
`define RAID0_STRIPE_REQUEST_SPLITTER_ASSERT_SVH

// Same-cycle implication.
`define RSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raid0 splitter check failed");

// Next-cycle implication.
`define RSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raid0 splitter check failed");

`endif

/* src/raid0s_pkg.sv */
package raid0s_pkg;

  localparam int STRIPE_BLOCK_BYTES_DEF = 4096;
  localparam int MAX_DEVICES_DEF        = 16;
  localparam int MAX_REQUEST_BLOCKS_DEF = 63;
  localparam int QUEUE_DEPTH            = 2;

  localparam int ADDR_W    = 48;
  localparam int COUNT_W   = 18;
  localparam int DEV_IDX_W = 4;
  localparam int LEN_W     = 13;
  localparam int DEV_CNT_W = 5;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_WRITE = 2'd1,
    ST_TOO_LONG   = 2'd2,
    ST_BELOW_BASE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_COUNT = 1'b0,
    CFG_REGION_BASE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_WALK
  } back_state_t;

  // One classified request as it waits between front and back.
  typedef struct packed {
    status_t              status;
    logic                 action;
    logic [ADDR_W-1:0]    offset;
    logic [ADDR_W-1:0]    host;
    logic [COUNT_W-1:0]   count;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/raid0s_front.sv */
module raid0s_front #(
  parameter int STRIPE_BLOCK_BYTES = raid0s_pkg::STRIPE_BLOCK_BYTES_DEF,
  parameter int MAX_REQUEST_BLOCKS = raid0s_pkg::MAX_REQUEST_BLOCKS_DEF
) (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [raid0s_pkg::ADDR_W-1:0]     in_volume_address,
  input  logic [raid0s_pkg::ADDR_W-1:0]     in_host_address,
  input  logic [raid0s_pkg::COUNT_W-1:0]    in_byte_count,
  input  logic [raid0s_pkg::ADDR_W-1:0]     region_base,
  input  raid0s_pkg::q_stat_t               q_stat,
  output logic                              q_push,
  output raid0s_pkg::req_t                  q_entry
);

  localparam logic [31:0] MAX_BYTES = 32'(MAX_REQUEST_BLOCKS * STRIPE_BLOCK_BYTES);

  logic zero_len;

  assign in_ready = !q_stat.full;
  assign zero_len = (in_byte_count == '0);

  // A zero-length read produces nothing, so it is simply dropped here.
  assign q_push = in_valid && in_ready && !(zero_len && !in_action);

  always_comb begin
    q_entry.action = in_action;
    q_entry.offset = in_volume_address - region_base;
    q_entry.host   = in_host_address;
    q_entry.count  = in_byte_count;
    if (zero_len) begin
      q_entry.status = raid0s_pkg::ST_ZERO_WRITE;
    end else if (in_volume_address < region_base) begin
      q_entry.status = raid0s_pkg::ST_BELOW_BASE;
    end else if ({14'd0, in_byte_count} > MAX_BYTES) begin
      q_entry.status = raid0s_pkg::ST_TOO_LONG;
    end else begin
      q_entry.status = raid0s_pkg::ST_OK;
    end
  end

endmodule

/* src/raid0s_queue.sv */
module raid0s_queue #(
  parameter int DEPTH = raid0s_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  raid0s_pkg::req_t     push_data,
  input  logic                 pop,
  output raid0s_pkg::req_t     pop_data,
  output raid0s_pkg::q_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  raid0s_pkg::req_t   entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (fill_r == CNT_W'(DEPTH));
  assign stat.empty = (fill_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/raid0s_back.sv */
`include "raid0_stripe_request_splitter_assert.svh"

module raid0s_back #(
  parameter int STRIPE_BLOCK_BYTES = raid0s_pkg::STRIPE_BLOCK_BYTES_DEF,
  parameter int MAX_DEVICES        = raid0s_pkg::MAX_DEVICES_DEF,
  localparam int NDEV_W            = $clog2(MAX_DEVICES + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [NDEV_W-1:0]                   ndev,
  input  raid0s_pkg::q_stat_t                 q_stat,
  input  raid0s_pkg::req_t                    q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic                                out_direction,
  output logic [raid0s_pkg::DEV_IDX_W-1:0]    out_device_index,
  output logic [raid0s_pkg::ADDR_W-1:0]       out_device_offset,
  output logic [raid0s_pkg::LEN_W-1:0]        out_chunk_length,
  output logic [raid0s_pkg::ADDR_W-1:0]       out_chunk_host_address,
  output logic                                out_last_chunk
);

  localparam int ADDR_W    = raid0s_pkg::ADDR_W;
  localparam int COUNT_W   = raid0s_pkg::COUNT_W;
  localparam int LOG2_BLK  = $clog2(STRIPE_BLOCK_BYTES);
  localparam int BLKNUM_W  = ADDR_W - LOG2_BLK;
  localparam int REM_W     = NDEV_W + 1;
  localparam int DIV_CNT_W = $clog2(BLKNUM_W + 1);
  localparam int CMP_W     = (COUNT_W > LOG2_BLK + 1) ? COUNT_W : LOG2_BLK + 1;

  raid0s_pkg::back_state_t state_r, state_nxt;

  logic [BLKNUM_W-1:0]  div_q_r, div_q_nxt;
  logic [REM_W-1:0]     div_rem_r, div_rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [BLKNUM_W-1:0]  blk_r, blk_nxt;
  logic [BLKNUM_W-1:0]  row_r, row_nxt;
  logic [NDEV_W-1:0]    dev_r, dev_nxt;
  logic [LOG2_BLK-1:0]  in_blk_r, in_blk_nxt;
  logic [COUNT_W-1:0]   left_r, left_nxt;
  logic [ADDR_W-1:0]    host_r, host_nxt;
  logic                 dir_r, dir_nxt;

  logic                 out_valid_r, out_valid_nxt;
  raid0s_pkg::status_t  out_status_r, out_status_nxt;
  logic                 out_dir_r, out_dir_nxt;
  logic [raid0s_pkg::DEV_IDX_W-1:0] out_dev_r, out_dev_nxt;
  logic [ADDR_W-1:0]    out_doff_r, out_doff_nxt;
  logic [raid0s_pkg::LEN_W-1:0] out_len_r, out_len_nxt;
  logic [ADDR_W-1:0]    out_host_r, out_host_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 slot_free;
  logic                 walk_load;
  logic [CMP_W-1:0]     room_w, avail_w, len_w;
  logic                 last_w;
  logic [REM_W-1:0]     trial_w;
  logic                 qbit_w;
  logic [REM_W-1:0]     rem_step_w;
  logic [BLKNUM_W-1:0]  q_step_w;

  assign slot_free = !out_valid_r || out_ready;
  assign walk_load = (state_r == raid0s_pkg::BK_WALK) && slot_free;

  // Chunk length: the rest of the current block or the rest of the request.
  assign room_w  = CMP_W'(STRIPE_BLOCK_BYTES) - CMP_W'(in_blk_r);
  assign avail_w = CMP_W'(left_r);
  assign len_w   = (room_w < avail_w) ? room_w : avail_w;
  assign last_w  = (avail_w == len_w);

  // One restoring division step of block number by device count.
  assign trial_w    = {div_rem_r[REM_W-2:0], div_q_r[BLKNUM_W-1]};
  assign qbit_w     = (trial_w >= REM_W'(ndev));
  assign rem_step_w = qbit_w ? trial_w - REM_W'(ndev) : trial_w;
  assign q_step_w   = {div_q_r[BLKNUM_W-2:0], qbit_w};

  always_comb begin
    state_nxt      = state_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_cnt_nxt    = div_cnt_r;
    blk_nxt        = blk_r;
    row_nxt        = row_r;
    dev_nxt        = dev_r;
    in_blk_nxt     = in_blk_r;
    left_nxt       = left_r;
    host_nxt       = host_r;
    dir_nxt        = dir_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_dir_nxt    = out_dir_r;
    out_dev_nxt    = out_dev_r;
    out_doff_nxt   = out_doff_r;
    out_len_nxt    = out_len_r;
    out_host_nxt   = out_host_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;

    unique case (state_r)
      raid0s_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          if (q_data.status == raid0s_pkg::ST_OK) begin
            q_pop       = 1'b1;
            div_q_nxt   = q_data.offset[ADDR_W-1:LOG2_BLK];
            blk_nxt     = q_data.offset[ADDR_W-1:LOG2_BLK];
            div_rem_nxt = '0;
            div_cnt_nxt = DIV_CNT_W'(BLKNUM_W);
            in_blk_nxt  = q_data.offset[LOG2_BLK-1:0];
            left_nxt    = q_data.count;
            host_nxt    = q_data.host;
            dir_nxt     = q_data.action;
            state_nxt   = raid0s_pkg::BK_DIVIDE;
          end else if (slot_free) begin
            q_pop          = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = q_data.status;
            out_dir_nxt    = q_data.action;
            out_dev_nxt    = '0;
            out_doff_nxt   = '0;
            out_len_nxt    = '0;
            out_host_nxt   = '0;
            out_last_nxt   = 1'b1;
          end
        end
      end
      raid0s_pkg::BK_DIVIDE: begin
        div_q_nxt   = q_step_w;
        div_rem_nxt = rem_step_w;
        div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(1)) begin
          row_nxt   = q_step_w;
          dev_nxt   = rem_step_w[NDEV_W-1:0];
          state_nxt = raid0s_pkg::BK_WALK;
        end
      end
      raid0s_pkg::BK_WALK: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = raid0s_pkg::ST_OK;
          out_dir_nxt    = dir_r;
          out_dev_nxt    = raid0s_pkg::DEV_IDX_W'(dev_r);
          out_doff_nxt   = {row_r, in_blk_r};
          out_len_nxt    = raid0s_pkg::LEN_W'(len_w);
          out_host_nxt   = host_r;
          out_last_nxt   = last_w;
          left_nxt       = left_r - COUNT_W'(len_w);
          host_nxt       = host_r + ADDR_W'(len_w);
          in_blk_nxt     = '0;
          // Next block; the volume cursor wraps to block zero past the top.
          if (&blk_r) begin
            blk_nxt = '0;
            row_nxt = '0;
            dev_nxt = '0;
          end else begin
            blk_nxt = blk_r + BLKNUM_W'(1);
            if (dev_r + NDEV_W'(1) == ndev) begin
              dev_nxt = '0;
              row_nxt = row_r + BLKNUM_W'(1);
            end else begin
              dev_nxt = dev_r + NDEV_W'(1);
            end
          end
          if (last_w) begin
            state_nxt = raid0s_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = raid0s_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= raid0s_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_q_r      <= div_q_nxt;
    div_rem_r    <= div_rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    blk_r        <= blk_nxt;
    row_r        <= row_nxt;
    dev_r        <= dev_nxt;
    in_blk_r     <= in_blk_nxt;
    left_r       <= left_nxt;
    host_r       <= host_nxt;
    dir_r        <= dir_nxt;
    out_status_r <= out_status_nxt;
    out_dir_r    <= out_dir_nxt;
    out_dev_r    <= out_dev_nxt;
    out_doff_r   <= out_doff_nxt;
    out_len_r    <= out_len_nxt;
    out_host_r   <= out_host_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_direction          = out_dir_r;
  assign out_device_index       = out_dev_r;
  assign out_device_offset      = out_doff_r;
  assign out_chunk_length       = out_len_r;
  assign out_chunk_host_address = out_host_r;
  assign out_last_chunk         = out_last_r;

  `RSS_ASSERT_IMP(a_chunk_not_empty, walk_load, len_w != '0)
  `RSS_ASSERT_IMP(a_dev_in_range, state_r == raid0s_pkg::BK_WALK, dev_r < ndev)
  `RSS_ASSERT_NXT(a_last_ends_walk, walk_load && last_w, state_r == raid0s_pkg::BK_IDLE)
  `RSS_ASSERT_IMP(a_pop_only_idle, q_pop, state_r == raid0s_pkg::BK_IDLE)
  `RSS_ASSERT_NXT(a_div_to_walk, state_r == raid0s_pkg::BK_DIVIDE && div_cnt_r == DIV_CNT_W'(1),
                  state_r == raid0s_pkg::BK_WALK)

endmodule

/* src/raid0_stripe_request_splitter.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    action, volume/host address, byte count
// out_      output     out_valid/out_ready  status, direction, device, offsets, length, last
// cfg_      input      cfg_we               cfg_index selects the register, cfg_data value
//
// A request is written into the queue at the edge that accepts it, and the back pops it
// once it is idle. The back then divides the block number by the device count one bit
// per cycle, and then gives the chunks, one per cycle while the output is not stalled,
// up to 64 with the default block size and limit. An error result goes from the queue
// to the output register when the back is idle and the output slot is free.
// Reset is synchronous and active low. A stalled output holds the back; the front keeps
// taking requests until the queue between them is full.

module raid0_stripe_request_splitter #(
  parameter int STRIPE_BLOCK_BYTES = raid0s_pkg::STRIPE_BLOCK_BYTES_DEF,
  parameter int MAX_DEVICES        = raid0s_pkg::MAX_DEVICES_DEF,
  parameter int MAX_REQUEST_BLOCKS = raid0s_pkg::MAX_REQUEST_BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [raid0s_pkg::ADDR_W-1:0]       in_volume_address,
  input  logic [raid0s_pkg::ADDR_W-1:0]       in_host_address,
  input  logic [raid0s_pkg::COUNT_W-1:0]      in_byte_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic                                out_direction,
  output logic [raid0s_pkg::DEV_IDX_W-1:0]    out_device_index,
  output logic [raid0s_pkg::ADDR_W-1:0]       out_device_offset,
  output logic [raid0s_pkg::LEN_W-1:0]        out_chunk_length,
  output logic [raid0s_pkg::ADDR_W-1:0]       out_chunk_host_address,
  output logic                                out_last_chunk,
  input  logic                                cfg_we,
  input  logic [raid0s_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [raid0s_pkg::ADDR_W-1:0]       cfg_data
);

  localparam int NDEV_W = $clog2(MAX_DEVICES + 1);

  logic [raid0s_pkg::DEV_CNT_W-1:0] device_count_r;
  logic [raid0s_pkg::ADDR_W-1:0]    region_base_r;
  logic [NDEV_W-1:0]                ndev;

  raid0s_pkg::q_stat_t q_stat;
  raid0s_pkg::req_t    q_entry;
  raid0s_pkg::req_t    q_head;
  logic                q_push;
  logic                q_pop;

  // Configuration registers. Write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_count_r <= raid0s_pkg::DEV_CNT_W'(1);
      region_base_r  <= '0;
    end else if (cfg_we) begin
      unique case (raid0s_pkg::cfg_reg_t'(cfg_index))
        raid0s_pkg::CFG_DEVICE_COUNT: device_count_r <= cfg_data[raid0s_pkg::DEV_CNT_W-1:0];
        raid0s_pkg::CFG_REGION_BASE:  region_base_r  <= cfg_data;
      endcase
    end
  end

  // A device count of zero acts as one, and counts above the supported
  // maximum are clamped to it.
  always_comb begin
    if (device_count_r == '0) begin
      ndev = NDEV_W'(1);
    end else if (int'(device_count_r) > MAX_DEVICES) begin
      ndev = NDEV_W'(MAX_DEVICES);
    end else begin
      ndev = NDEV_W'(device_count_r);
    end
  end

  // The front classifies each transaction and queues it; zero-length reads
  // are dropped there since they produce no result.
  raid0s_front #(
    .STRIPE_BLOCK_BYTES (STRIPE_BLOCK_BYTES),
    .MAX_REQUEST_BLOCKS (MAX_REQUEST_BLOCKS)
  ) u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_volume_address (in_volume_address),
    .in_host_address   (in_host_address),
    .in_byte_count     (in_byte_count),
    .region_base       (region_base_r),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_entry           (q_entry)
  );

  raid0s_queue #(
    .DEPTH (raid0s_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .pop_data  (q_head),
    .stat      (q_stat)
  );

  // The back divides for each valid request and then walks it block by block, one chunk
  // per output transaction; a request with an error status gives a single result.
  raid0s_back #(
    .STRIPE_BLOCK_BYTES (STRIPE_BLOCK_BYTES),
    .MAX_DEVICES        (MAX_DEVICES)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ndev                   (ndev),
    .q_stat                 (q_stat),
    .q_data                 (q_head),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_direction          (out_direction),
    .out_device_index       (out_device_index),
    .out_device_offset      (out_device_offset),
    .out_chunk_length       (out_chunk_length),
    .out_chunk_host_address (out_chunk_host_address),
    .out_last_chunk         (out_last_chunk)
  );

endmodule
